@@ hw/rtl/rshf_pkg.sv @@
// shared types and constants for the single-pixel hole fill block
package rshf_pkg;

  localparam int PIX_W          = 8;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int FRAME_SIZE_RST = 1024;
  localparam int OUT_FIFO_DEPTH = 3;

  typedef logic [PIX_W-1:0] pix_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_FILL_COLOR   = 2'd2
  } cfg_idx_t;

  // input word kinds
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  // decision controls handed from the address stage to the decide stage
  typedef struct packed {
    logic emit;
    logic left_chk;
    logic right_chk;
    logic up_chk;
    logic lower_chk;
    pix_t lower;
    logic frame_end;
  } s1_ctl_t;

  // one result word
  typedef struct packed {
    pix_t result_pixel;
    logic was_filled;
    logic frame_end;
  } res_word_t;

endpackage

@@ hw/rtl/rshf_ram.sv @@
// generic single-write single-read ram with registered read, read-before-write
module rshf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // same-address read in a write cycle returns the old entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/rshf_ctrl.sv @@
// raster counters, row-store addressing and decision controls for each word
module rshf_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_cmd,
  input  rshf_pkg::pix_t                      in_pixel_value,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      frame_width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     frame_height,
  output logic [$clog2(MAX_WIDTH)-1:0]        col_sel,
  output logic [$clog2(MAX_WIDTH)-1:0]        col_right,
  output logic                                pend_we,
  output rshf_pkg::s1_ctl_t                   s1_r,
  output logic [$clog2(MAX_WIDTH)-1:0]        s1_col_r
);
  import rshf_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WSZ_W = $clog2(MAX_WIDTH+1);
  localparam int ROW_W = $clog2(MAX_HEIGHT+1);

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic             out_row_nz_r, out_row_nz_nxt;
  logic [COL_W-1:0] ic, oc;
  logic             ic_last, oc_last;
  logic             row_live;
  logic             acc;
  logic             is_drain;
  s1_ctl_t          s1_nxt;

  // next raster position and decision controls
  always_comb begin
    acc      = in_valid && !in_stall;
    is_drain = (cmd_t'(in_cmd) == CMD_DRAIN);
    ic       = (WSZ_W'(in_col_r) >= frame_width) ? '0 : in_col_r;
    oc       = (WSZ_W'(out_col_r) >= frame_width) ? '0 : out_col_r;
    ic_last  = (WSZ_W'(ic) + WSZ_W'(1)) >= frame_width;
    oc_last  = (WSZ_W'(oc) + WSZ_W'(1)) >= frame_width;
    row_live = in_row_r < frame_height;

    in_col_nxt     = ic;
    out_col_nxt    = oc;
    in_row_nxt     = in_row_r;
    out_row_nz_nxt = out_row_nz_r;
    s1_nxt         = '0;
    col_sel        = ic;
    pend_we        = 1'b0;

    if (!is_drain) begin
      if (row_live) begin
        // decide the pixel above, then store this one into the pending row
        pend_we          = acc;
        s1_nxt.emit      = (in_row_r != '0);
        s1_nxt.left_chk  = (ic != '0);
        s1_nxt.right_chk = !ic_last;
        s1_nxt.up_chk    = (in_row_r > ROW_W'(1));
        s1_nxt.lower_chk = 1'b1;
        s1_nxt.lower     = in_pixel_value;
        if (in_row_r != '0) begin
          out_row_nz_nxt = (in_row_r > ROW_W'(1));
          out_col_nxt    = ic;
        end
        if (ic_last) begin
          in_col_nxt  = '0;
          in_row_nxt  = in_row_r + ROW_W'(1);
          out_col_nxt = '0;
          if (in_row_nxt >= frame_height) begin
            out_row_nz_nxt = 1'b1;
          end
        end else begin
          in_col_nxt = COL_W'(ic + COL_W'(1));
        end
      end
    end else begin
      col_sel = oc;
      if (!row_live) begin
        // release one pixel of the last row
        s1_nxt.emit      = 1'b1;
        s1_nxt.left_chk  = (oc != '0);
        s1_nxt.right_chk = !oc_last;
        s1_nxt.up_chk    = out_row_nz_r;
        s1_nxt.frame_end = oc_last;
        if (oc_last) begin
          in_col_nxt     = '0;
          out_col_nxt    = '0;
          in_row_nxt     = '0;
          out_row_nz_nxt = 1'b0;
        end else begin
          out_col_nxt = COL_W'(oc + COL_W'(1));
        end
      end
    end

    col_right = COL_W'(col_sel + COL_W'(1));
  end

  // raster state and stage-one controls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r     <= '0;
      out_col_r    <= '0;
      in_row_r     <= '0;
      out_row_nz_r <= 1'b0;
      s1_r         <= '0;
    end else begin
      if (acc) begin
        in_col_r     <= in_col_nxt;
        out_col_r    <= out_col_nxt;
        in_row_r     <= in_row_nxt;
        out_row_nz_r <= out_row_nz_nxt;
      end
      s1_r <= acc ? s1_nxt : '0;
    end
  end

  // column address of the word in the decide stage
  always_ff @(posedge clk) begin
    s1_col_r <= col_sel;
  end

  // the last drain word of a frame rewinds the raster
  a_frame_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_drain && !row_live && oc_last) |=> (in_row_r == '0 && in_col_r == '0))
    else $error("raster not rewound after frame end");

endmodule

@@ hw/rtl/rshf_decide.sv @@
// neighbour compare, fill decision and update of the decided-row store
module rshf_decide #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rshf_pkg::s1_ctl_t             s1,
  input  logic [$clog2(MAX_WIDTH)-1:0]  s1_col,
  input  rshf_pkg::pix_t                cur_pix,
  input  rshf_pkg::pix_t                right_pix,
  input  rshf_pkg::pix_t                up_pix,
  input  rshf_pkg::pix_t                fill_color,
  output logic                          upd_we,
  output logic [$clog2(MAX_WIDTH)-1:0]  upd_addr,
  output rshf_pkg::pix_t                upd_data,
  output logic                          push,
  output rshf_pkg::res_word_t           push_word
);
  import rshf_pkg::*;

  pix_t left_r;
  logic ok;
  logic filled;
  pix_t res;

  // every neighbour that exists must already hold the fill colour
  always_comb begin
    ok = !(s1.up_chk && (up_pix != fill_color))
      && !(s1.left_chk && (left_r != fill_color))
      && !(s1.right_chk && (right_pix != fill_color))
      && !(s1.lower_chk && (s1.lower != fill_color));
    filled = (cur_pix != fill_color) && ok;
    res    = filled ? fill_color : cur_pix;
  end

  assign upd_we                 = s1.emit;
  assign upd_addr               = s1_col;
  assign upd_data               = res;
  assign push                   = s1.emit;
  assign push_word.result_pixel = res;
  assign push_word.was_filled   = filled;
  assign push_word.frame_end    = s1.frame_end;

  // left neighbour is the last decided pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1.emit) begin
      left_r <= res;
    end
  end

endmodule

@@ hw/rtl/rshf_out_fifo.sv @@
// three-word result queue that decouples the decide stage from the output
module rshf_out_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rshf_pkg::res_word_t  push_word,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rshf_pkg::res_word_t  out_word
);
  import rshf_pkg::*;

  localparam int DEPTH = OUT_FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  res_word_t        entry_r [DEPTH];
  logic [PTR_W-1:0] head_r, tail_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign out_word  = entry_r[head_r];
  assign pop       = out_valid && !out_stall;
  // room for the word in the decide stage plus one more
  assign busy      = ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(push)) >= (CNT_W+1)'(DEPTH);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        tail_r <= (tail_r == PTR_W'(DEPTH-1)) ? '0 : PTR_W'(tail_r + PTR_W'(1));
      end
      if (pop) begin
        head_r <= (head_r == PTR_W'(DEPTH-1)) ? '0 : PTR_W'(head_r + PTR_W'(1));
      end
      if (push && !pop) begin
        cnt_r <= CNT_W'(cnt_r + CNT_W'(1));
      end else if (pop && !push) begin
        cnt_r <= CNT_W'(cnt_r - CNT_W'(1));
      end
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[tail_r] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((cnt_r < CNT_W'(DEPTH)) || pop))
    else $error("result queue overflow");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue level out of range");

endmodule

@@ hw/rtl/raster_single_pixel_hole_fill_core.sv @@
// top level of the four-neighbour single-pixel hole fill block
// Pixels enter in raster order, one word per clock while in_stall is low,
// and each result word leaves one row later: the pixel at (r+1, c) releases
// the decision for (r, c), and after the last row one drain word (cmd = 1)
// releases each of its pixels, the last carrying frame_end. The sustained
// rate is one word per cycle while the output is not stalled; a released word
// is registered in the stage-one controls and then in the result queue.
// Two row stores hold the state: the decided previous row, and the received
// row being decided, kept as two identical copies so that the pixel and its
// right neighbour are read in the same cycle. Each store has a registered
// read ahead of the decide stage; the decided row is written back in the
// decide stage and the received row as each pixel is accepted. A three-word
// result queue lets input continue while the output is stalled. Frame size
// is clamped to [2, MAX_WIDTH] x [2, MAX_HEIGHT]; there is no clearing pass after reset.
module raster_single_pixel_hole_fill_core #(
  parameter int MAX_WIDTH  = rshf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rshf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  rshf_pkg::pix_t                      in_pixel_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rshf_pkg::pix_t                      out_result_pixel,
  output logic                                out_was_filled,
  output logic                                out_frame_end,
  input  logic                                cfg_wr_en,
  input  logic [rshf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rshf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rshf_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WSZ_W = $clog2(MAX_WIDTH+1);
  localparam int ROW_W = $clog2(MAX_HEIGHT+1);
  localparam int CW_W  = (WSZ_W > CFG_DATA_W) ? WSZ_W : CFG_DATA_W;
  localparam int CH_W  = (ROW_W > CFG_DATA_W) ? ROW_W : CFG_DATA_W;
  localparam int RST_W = (FRAME_SIZE_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_SIZE_RST;
  localparam int RST_H = (FRAME_SIZE_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_SIZE_RST;

  logic [WSZ_W-1:0] frame_width_r, width_clamped;
  logic [ROW_W-1:0] frame_height_r, height_clamped;
  pix_t             fill_color_r;
  logic [CW_W-1:0]  cfg_w_ext;
  logic [CH_W-1:0]  cfg_h_ext;

  logic [COL_W-1:0] col_sel, col_right, s1_col;
  logic             pend_we;
  s1_ctl_t          s1;
  pix_t             cur_pix, right_pix, up_pix;
  logic             upd_we;
  logic [COL_W-1:0] upd_addr;
  pix_t             upd_data;
  logic             push;
  res_word_t        push_word, out_word;

  // clamp written sizes into the supported range
  always_comb begin
    cfg_w_ext = CW_W'(cfg_data);
    cfg_h_ext = CH_W'(cfg_data);
    if (cfg_w_ext < CW_W'(2)) begin
      width_clamped = WSZ_W'(2);
    end else if (cfg_w_ext > CW_W'(MAX_WIDTH)) begin
      width_clamped = WSZ_W'(MAX_WIDTH);
    end else begin
      width_clamped = WSZ_W'(cfg_w_ext);
    end
    if (cfg_h_ext < CH_W'(2)) begin
      height_clamped = ROW_W'(2);
    end else if (cfg_h_ext > CH_W'(MAX_HEIGHT)) begin
      height_clamped = ROW_W'(MAX_HEIGHT);
    end else begin
      height_clamped = ROW_W'(cfg_h_ext);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WSZ_W'(RST_W);
      frame_height_r <= ROW_W'(RST_H);
      fill_color_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= width_clamped;
        CFG_FRAME_HEIGHT: frame_height_r <= height_clamped;
        CFG_FILL_COLOR:   fill_color_r   <= PIX_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // raster control and store addressing
  rshf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_pixel_value (in_pixel_value),
    .frame_width    (frame_width_r),
    .frame_height   (frame_height_r),
    .col_sel        (col_sel),
    .col_right      (col_right),
    .pend_we        (pend_we),
    .s1_r           (s1),
    .s1_col_r       (s1_col)
  );

  // received row, copy read at the pixel's own column
  rshf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_pend_cur (
    .clk     (clk),
    .wr_en   (pend_we),
    .wr_addr (col_sel),
    .wr_data (in_pixel_value),
    .rd_addr (col_sel),
    .rd_data (cur_pix)
  );

  // received row, copy read at the right neighbour
  rshf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_pend_right (
    .clk     (clk),
    .wr_en   (pend_we),
    .wr_addr (col_sel),
    .wr_data (in_pixel_value),
    .rd_addr (col_right),
    .rd_data (right_pix)
  );

  // decided previous row
  rshf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upd (
    .clk     (clk),
    .wr_en   (upd_we),
    .wr_addr (upd_addr),
    .wr_data (upd_data),
    .rd_addr (col_sel),
    .rd_data (up_pix)
  );

  // fill decision
  rshf_decide #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1         (s1),
    .s1_col     (s1_col),
    .cur_pix    (cur_pix),
    .right_pix  (right_pix),
    .up_pix     (up_pix),
    .fill_color (fill_color_r),
    .upd_we     (upd_we),
    .upd_addr   (upd_addr),
    .upd_data   (upd_data),
    .push       (push),
    .push_word  (push_word)
  );

  // result queue
  rshf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .busy      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign out_result_pixel = out_word.result_pixel;
  assign out_was_filled   = out_word.was_filled;
  assign out_frame_end    = out_word.frame_end;

endmodule

@@ bench/fill_decision_pkg.sv @@
// expected-result tracking and checking for the single-pixel hole fill bench
package fill_decision_pkg;
  import rshf_pkg::*;

  localparam int MAX_W      = DEF_MAX_WIDTH;
  localparam int MAX_H      = DEF_MAX_HEIGHT;
  localparam int MAX_PRINTS = 20;

  // frame sizes are used clamped into [2, max]
  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  class fill_decision_tracker;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    pix_t                  fill_reg;
    pix_t                  decided_row [MAX_W];
    pix_t                  received_row [MAX_W];
    pix_t                  left_decided;
    int unsigned           in_row;
    int unsigned           in_col;
    int unsigned           out_row;
    int unsigned           out_col;
    res_word_t             awaited_decisions [$];
    int unsigned           errors;

    function new();
      width_reg    = CFG_DATA_W'(FRAME_SIZE_RST);
      height_reg   = CFG_DATA_W'(FRAME_SIZE_RST);
      fill_reg     = '0;
      left_decided = '0;
      in_row       = 0;
      in_col       = 0;
      out_row      = 0;
      out_col      = 0;
      errors       = 0;
      foreach (decided_row[i]) begin
        decided_row[i]  = '0;
        received_row[i] = '0;
      end
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FRAME_WIDTH: width_reg = value;
        CFG_FRAME_HEIGHT: height_reg = value;
        CFG_FILL_COLOR: fill_reg = value[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return awaited_decisions.size();
    endfunction

    // decide pixel (out_row, out_col) in place and queue the word it gives
    function void decide_pixel(int unsigned w, bit has_lower, pix_t lower, bit last);
      pix_t      cur;
      bit        surrounded;
      res_word_t word;
      cur        = received_row[out_col];
      surrounded = 1'b1;
      if (out_row > 0 && decided_row[out_col] != fill_reg) surrounded = 1'b0;
      if (out_col > 0 && left_decided != fill_reg) surrounded = 1'b0;
      if (out_col + 1 < w && received_row[out_col + 1] != fill_reg) surrounded = 1'b0;
      if (has_lower && lower != fill_reg) surrounded = 1'b0;
      word.was_filled   = (cur != fill_reg) && surrounded;
      word.result_pixel = word.was_filled ? fill_reg : cur;
      word.frame_end    = last;
      decided_row[out_col] = word.result_pixel;
      left_decided         = word.result_pixel;
      awaited_decisions.push_back(word);
    endfunction

    // advance the frame position for one accepted input word
    function void take_word(cmd_t cmd, pix_t px);
      int unsigned w;
      int unsigned h;
      w = clamp_size(width_reg, MAX_W);
      h = clamp_size(height_reg, MAX_H);
      if (in_col >= w) in_col = 0;
      if (out_col >= w) out_col = 0;
      if (cmd == CMD_PIXEL) begin
        // pixels past the last row are dropped
        if (in_row >= h) return;
        // a pixel in row r+1 releases the decision above it
        if (in_row > 0) begin
          out_row = in_row - 1;
          out_col = in_col;
          decide_pixel(w, 1'b1, px, 1'b0);
        end
        received_row[in_col] = px;
        if (in_col + 1 >= w) begin
          in_col  = 0;
          in_row  = in_row + 1;
          out_col = 0;
          if (in_row >= h) out_row = in_row - 1;
        end else begin
          in_col = in_col + 1;
        end
      end else if (in_row >= h) begin
        // drain words release the last row, one pixel each
        if (out_col + 1 >= w) begin
          decide_pixel(w, 1'b0, '0, 1'b1);
          in_row  = 0;
          in_col  = 0;
          out_row = 0;
          out_col = 0;
        end else begin
          decide_pixel(w, 1'b0, '0, 1'b0);
          out_col = out_col + 1;
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t mismatch: %s", $time, msg);
    endtask

    // compare one delivered word against the oldest awaited decision
    task match_decision(res_word_t got);
      res_word_t want;
      if (awaited_decisions.size() == 0) begin
        report_mismatch($sformatf("unexpected word pixel=%0d filled=%0b end=%0b",
                                  got.result_pixel, got.was_filled, got.frame_end));
        return;
      end
      want = awaited_decisions.pop_front();
      if (got.result_pixel !== want.result_pixel)
        report_mismatch($sformatf("result_pixel got %0d want %0d",
                                  got.result_pixel, want.result_pixel));
      if (got.was_filled !== want.was_filled)
        report_mismatch($sformatf("was_filled got %0b want %0b",
                                  got.was_filled, want.was_filled));
      if (got.frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end got %0b want %0b",
                                  got.frame_end, want.frame_end));
    endtask
  endclass

endpackage

@@ bench/raster_single_pixel_hole_fill_core_test.sv @@
// top-level bench for the single-pixel hole fill block: stimulus, pacing and checks
module raster_single_pixel_hole_fill_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rshf_pkg::*;
  import fill_decision_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 8;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int TARGET_WORDS  = 1600;
  localparam int QUIET_FROM    = 1300;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic                  in_cmd         = CMD_PIXEL;
  pix_t                  in_pixel_value = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  pix_t                  out_result_pixel;
  logic                  out_was_filled;
  logic                  out_frame_end;
  logic                  cfg_wr_en      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  fill_decision_tracker  fill_tracker = new();
  bit                    tx_gaps;
  bit                    rx_gaps;
  bit                    hold_request;
  int unsigned           words_sent;
  int unsigned           frame_w;
  int unsigned           frame_h;
  pix_t                  fill_now;
  int unsigned           cycles_without_word;

  raster_single_pixel_hole_fill_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_pixel_value   (in_pixel_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_pixel (out_result_pixel),
    .out_was_filled   (out_was_filled),
    .out_frame_end    (out_frame_end),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // free-running clock
  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // note accepted input words and check accepted result words
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) fill_tracker.take_word(cmd_t'(in_cmd), in_pixel_value);
      if (out_valid && !out_stall)
        fill_tracker.match_decision(res_word_t'{out_result_pixel, out_was_filled,
                                                out_frame_end});
    end
  end

  // watchdog on stretches with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      cycles_without_word <= 0;
    end else begin
      cycles_without_word <= cycles_without_word + 1;
    end
    if (cycles_without_word >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output side pacing: random stall bursts and one long hold-off on request
  initial begin : result_pacing
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one word and wait for it to be taken
  task automatic send_word(cmd_t cmd, pix_t px);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= cmd;
    in_pixel_value <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and let every awaited word and any trailing work finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (fill_tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    fill_tracker.set_reg(idx, value);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame_format(logic [CFG_DATA_W-1:0] raw_w,
                                  logic [CFG_DATA_W-1:0] raw_h, pix_t fc);
    write_reg(CFG_FRAME_WIDTH, raw_w);
    write_reg(CFG_FRAME_HEIGHT, raw_h);
    write_reg(CFG_FILL_COLOR, CFG_DATA_W'(fc));
    frame_w  = clamp_size(raw_w, MAX_W);
    frame_h  = clamp_size(raw_h, MAX_H);
    fill_now = fc;
  endtask

  // pixel content: fully random, fill-heavy, or fill with single-bit holes
  function automatic pix_t pick_pixel(int style);
    case (style)
      0: return pix_t'($urandom_range(0, 255));
      1: return ($urandom_range(0, 3) == 0) ? pix_t'($urandom_range(0, 255)) : fill_now;
      default: return ($urandom_range(0, 6) == 0) ?
                      fill_now ^ pix_t'(1 << $urandom_range(0, PIX_W - 1)) : fill_now;
    endcase
  endfunction

  // one whole frame plus its drain words, optionally with ignored words mixed in
  task automatic send_frame(int style, bit noisy, bit press);
    for (int unsigned r = 0; r < frame_h; r++) begin
      for (int unsigned c = 0; c < frame_w; c++) begin
        if (press && r == 1 && c == 0) hold_request = 1'b1;
        // drain before the last row is complete is dropped
        if (noisy && $urandom_range(0, 15) == 0) send_word(CMD_DRAIN, pix_t'($urandom));
        send_word(CMD_PIXEL, pick_pixel(style));
        words_sent++;
      end
    end
    for (int unsigned c = 0; c < frame_w; c++) begin
      // pixel while draining is dropped
      if (noisy && $urandom_range(0, 15) == 0) send_word(CMD_PIXEL, pick_pixel(0));
      send_word(CMD_DRAIN, pix_t'($urandom));
      words_sent++;
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] raw_w;
    logic [CFG_DATA_W-1:0] raw_h;
    pix_t                  fc;
    int unsigned           frames;
    bit                    first_phase;
    bit                    quiet;

    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    hold_request = 1'b0;
    words_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2 frame from undersized registers, fill 255, with dropped words
    set_frame_format(11'd1, 11'd0, 8'hFF);
    send_word(CMD_DRAIN, 8'h5A);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_DRAIN, 8'hA5);
    send_word(CMD_DRAIN, 8'hFF);
    wait_idle();

    // 4-wide frame, fill 0, width shrinks to 2 part way through the second row
    set_frame_format(11'd4, 11'd2, 8'h00);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'h80);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'h7F);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'h00);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, 11'd2);
    send_word(CMD_PIXEL, 8'h01);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_DRAIN, 8'h00);
    send_word(CMD_DRAIN, 8'h00);
    wait_idle();

    // random small frames until enough words have gone in
    words_sent  = 0;
    first_phase = 1'b1;
    while (words_sent < TARGET_WORDS) begin
      quiet   = (words_sent >= QUIET_FROM);
      tx_gaps = !quiet && ($urandom_range(0, 3) != 0);
      rx_gaps = !quiet && ($urandom_range(0, 3) != 0);
      raw_w = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
                                          : CFG_DATA_W'($urandom_range(2, 12));
      raw_h = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(0, 1))
                                          : CFG_DATA_W'($urandom_range(2, 6));
      case ($urandom_range(0, 5))
        0: fc = 8'h00;
        1: fc = 8'hFF;
        default: fc = pix_t'($urandom_range(0, 255));
      endcase
      if (first_phase) begin
        raw_w = 11'd8;
        raw_h = 11'd4;
      end
      set_frame_format(raw_w, raw_h, fc);
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        send_frame($urandom_range(0, 2), $urandom_range(0, 2) == 0, first_phase && f == 0);
      end
      wait_idle();
      first_phase = 1'b0;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fill_tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
